FILE: hdl/tdl_pkg.sv
// Shared types and constants for the tile directory decode and lookup unit.
// No dependencies; used by every module of the block but tdl_ram.
package tdl_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 1024;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] ST_LOADED    = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_HIT       = 3'd3;
   localparam logic [2:0] ST_LEAF      = 3'd4;
   localparam logic [2:0] ST_MISS      = 3'd5;

   typedef struct packed {
      logic        is_lookup;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [63:0] query_tile_id;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

FILE: hdl/tdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tdl_front.sv
// Front end: accepts request beats, classifies them and queues them.
// Depends on tdl_pkg.
module tdl_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   input  logic [63:0]             req_query_tile_id,
   output tdl_pkg::queue_head_type head,
   input  logic                    pop
);

   localparam int PW = (tdl_pkg::QUEUE_DEPTH > 1) ? $clog2(tdl_pkg::QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(tdl_pkg::QUEUE_DEPTH + 1);

   tdl_pkg::item_type slot_ff [tdl_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic push;
   tdl_pkg::item_type item;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      if (p == PW'(tdl_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      item.is_lookup     = req_command;
      item.data_byte     = req_data_byte;
      item.last_byte     = req_last_byte;
      item.query_tile_id = req_query_tile_id;
   end

   assign req_ready  = (count_ff != NW'(tdl_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/tdl_back.sv
// Back end: varint stream decoder, entry table writer, binary search and result register.
// Depends on tdl_pkg and tdl_ram.
module tdl_back #(
   parameter int MAX_ENTRIES = tdl_pkg::MAX_ENTRIES_DEFAULT,
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tdl_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [CW-1:0]           rsp_entry_count,
   output logic [63:0]             rsp_found_tile_id,
   output logic [63:0]             rsp_found_offset,
   output logic [31:0]             rsp_found_length,
   output logic [31:0]             rsp_found_run
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_OFFADD = 5'b00010,
      S_SRD    = 5'b00100,
      S_SCMP   = 5'b01000,
      S_FIN    = 5'b10000
   } state_type;

   typedef enum logic [6:0] {
      PH_COUNT = 7'b0000001,
      PH_IDS   = 7'b0000010,
      PH_RUNS  = 7'b0000100,
      PH_LENS  = 7'b0001000,
      PH_OFFS  = 7'b0010000,
      PH_DONE  = 7'b0100000,
      PH_BIG   = 7'b1000000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [63:0]   acc_ff, acc_in;
   logic [3:0]    vidx_ff, vidx_in;
   logic [CW-1:0] declared_ff, declared_in, ci_ff, ci_in, valid_cnt_ff, valid_cnt_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [63:0]   run_id_ff, run_id_in, prev_end_ff, prev_end_in, off_ff, off_in;
   logic [63:0]   query_ff, query_in;
   logic          last_ff, last_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0]   fid_ff, fid_in, foff_ff, foff_in;
   logic [31:0]   flen_ff, flen_in, frun_ff, frun_in;

   logic          id_we, run_we, len_we, off_we;
   logic [63:0]   wdata64, off_wdata;
   logic [31:0]   wdata32;
   logic [AW-1:0] raddr;
   logic [63:0]   id_rd, off_rd;
   logic [31:0]   run_rd, len_rd;

   logic          take, do_finish, fin_pending, adv;
   logic [63:0]   shifted, v, off_val;
   logic [CW-1:0] ci_next;

   function automatic phase_type next_phase(input phase_type p);
      case (p)
         PH_IDS:  return PH_RUNS;
         PH_RUNS: return PH_LENS;
         PH_LENS: return PH_OFFS;
         PH_OFFS: return PH_DONE;
         default: return p;
      endcase
   endfunction

   assign take = (state_ff == S_IDLE) && head.valid && !rsp_valid_ff;
   assign pop  = take;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      vidx_in      = vidx_ff;
      declared_in  = declared_ff;
      ci_in        = ci_ff;
      valid_cnt_in = valid_cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      run_id_in    = run_id_ff;
      prev_end_in  = prev_end_ff;
      off_in       = off_ff;
      query_in     = query_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      count_in     = count_ff;
      fid_in       = fid_ff;
      foff_in      = foff_ff;
      flen_in      = flen_ff;
      frun_in      = frun_ff;
      id_we        = 1'b0;
      run_we       = 1'b0;
      len_we       = 1'b0;
      off_we       = 1'b0;
      wdata64      = '0;
      wdata32      = '0;
      off_val      = '0;
      raddr        = '0;
      do_finish    = 1'b0;
      fin_pending  = 1'b0;
      adv          = 1'b0;
      shifted      = 64'({57'd0, head.item.data_byte[6:0]} << (7'(vidx_ff) * 7'd7));
      v            = acc_ff | shifted;
      ci_next      = ci_ff + 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (take && head.item.is_lookup) begin
               query_in = head.item.query_tile_id;
               lo_in    = '0;
               hi_in    = valid_cnt_ff;
               state_in = S_SRD;
            end else if (take) begin
               valid_cnt_in = '0;
               do_finish    = head.item.last_byte;
               if (phase_ff != PH_DONE && phase_ff != PH_BIG) begin
                  if (head.item.data_byte[7]) begin
                     acc_in      = v;
                     vidx_in     = (vidx_ff == 4'd15) ? vidx_ff : vidx_ff + 1'b1;
                     fin_pending = 1'b1;
                  end else begin
                     acc_in  = '0;
                     vidx_in = '0;
                     case (phase_ff)
                        PH_COUNT: begin
                           if (v > 64'(MAX_ENTRIES)) begin
                              phase_in = PH_BIG;
                           end else if (v == '0) begin
                              declared_in = '0;
                              phase_in    = PH_DONE;
                           end else begin
                              declared_in = v[CW-1:0];
                              ci_in       = '0;
                              run_id_in   = '0;
                              phase_in    = PH_IDS;
                           end
                        end
                        PH_IDS: begin
                           run_id_in = run_id_ff + v;
                           wdata64   = run_id_in;
                           id_we     = 1'b1;
                           adv       = 1'b1;
                        end
                        PH_RUNS: begin
                           wdata32 = v[31:0];
                           run_we  = 1'b1;
                           adv     = 1'b1;
                        end
                        PH_LENS: begin
                           wdata32 = v[31:0];
                           len_we  = 1'b1;
                           adv     = 1'b1;
                        end
                        PH_OFFS: begin
                           if (ci_ff != '0 && v == '0) begin
                              off_val = prev_end_ff;
                           end else if (v != '0) begin
                              off_val = v - 64'd1;
                           end else begin
                              off_val = '0;
                           end
                           off_we    = 1'b1;
                           off_in    = off_val;
                           raddr     = ci_ff[AW-1:0];
                           last_in   = head.item.last_byte;
                           do_finish = 1'b0;
                           state_in  = S_OFFADD;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
         end
         S_OFFADD: begin
            prev_end_in = off_ff + {32'd0, len_rd};
            adv         = 1'b1;
            do_finish   = last_ff;
            state_in    = S_IDLE;
         end
         S_SRD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               raddr    = mid_in[AW-1:0];
               state_in = S_SCMP;
            end else if (lo_ff == '0) begin
               rsp_valid_in = 1'b1;
               status_in    = tdl_pkg::ST_MISS;
               count_in     = valid_cnt_ff;
               fid_in       = '0;
               foff_in      = '0;
               flen_in      = '0;
               frun_in      = '0;
               state_in     = S_IDLE;
            end else begin
               raddr    = AW'(lo_ff - 1'b1);
               state_in = S_FIN;
            end
         end
         S_SCMP: begin
            if (query_ff < id_rd) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = S_SRD;
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            count_in     = valid_cnt_ff;
            fid_in       = id_rd;
            foff_in      = off_rd;
            flen_in      = len_rd;
            frun_in      = run_rd;
            if (run_rd == '0) begin
               status_in = tdl_pkg::ST_LEAF;
            end else if ((query_ff - id_rd) < {32'd0, run_rd}) begin
               status_in = tdl_pkg::ST_HIT;
            end else begin
               status_in = tdl_pkg::ST_MISS;
               fid_in    = '0;
               foff_in   = '0;
               flen_in   = '0;
               frun_in   = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv) begin
         if (ci_next >= declared_ff) begin
            ci_in    = '0;
            phase_in = next_phase(phase_ff);
         end else begin
            ci_in = ci_next;
         end
      end

      if (do_finish) begin
         if (phase_in == PH_DONE && !fin_pending) begin
            status_in    = tdl_pkg::ST_LOADED;
            valid_cnt_in = declared_in;
         end else if (phase_in == PH_BIG) begin
            status_in = tdl_pkg::ST_TOO_LARGE;
         end else begin
            status_in = tdl_pkg::ST_TRUNCATED;
         end
         rsp_valid_in = 1'b1;
         count_in     = valid_cnt_in;
         fid_in       = '0;
         foff_in      = '0;
         flen_in      = '0;
         frun_in      = '0;
         acc_in       = '0;
         vidx_in      = '0;
         phase_in     = PH_COUNT;
         declared_in  = '0;
         ci_in        = '0;
         run_id_in    = '0;
         prev_end_in  = '0;
      end
   end

   assign off_wdata = off_val;

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      off_ff    <= off_in;
      query_ff  <= query_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      fid_ff    <= fid_in;
      foff_ff   <= foff_in;
      flen_ff   <= flen_in;
      frun_ff   <= frun_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_COUNT;
         acc_ff       <= '0;
         vidx_ff      <= '0;
         declared_ff  <= '0;
         ci_ff        <= '0;
         valid_cnt_ff <= '0;
         run_id_ff    <= '0;
         prev_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         vidx_ff      <= vidx_in;
         declared_ff  <= declared_in;
         ci_ff        <= ci_in;
         valid_cnt_ff <= valid_cnt_in;
         run_id_ff    <= run_id_in;
         prev_end_ff  <= prev_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   tdl_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_id_ram (
      .clock(clock), .wr_en(id_we), .wr_addr(ci_ff[AW-1:0]), .wr_data(wdata64),
      .rd_addr(raddr), .rd_data(id_rd)
   );

   tdl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_run_ram (
      .clock(clock), .wr_en(run_we), .wr_addr(ci_ff[AW-1:0]), .wr_data(wdata32),
      .rd_addr(raddr), .rd_data(run_rd)
   );

   tdl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_len_ram (
      .clock(clock), .wr_en(len_we), .wr_addr(ci_ff[AW-1:0]), .wr_data(wdata32),
      .rd_addr(raddr), .rd_data(len_rd)
   );

   tdl_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_off_ram (
      .clock(clock), .wr_en(off_we), .wr_addr(ci_ff[AW-1:0]), .wr_data(off_wdata),
      .rd_addr(raddr), .rd_data(off_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_found_tile_id = fid_ff;
   assign rsp_found_offset  = foff_ff;
   assign rsp_found_length  = flen_ff;
   assign rsp_found_run     = frun_ff;

endmodule

FILE: hdl/tile_directory_decode_lookup_unit.sv
// Every beat passes through a two-beat queue that parts intake from the back end.
// A load beat is handled in S_IDLE; one that completes an offset also passes S_OFFADD,
// to read back its length. A lookup is a binary search: each search step is a
// registered id RAM read plus a compare, then one read of the found entry. A pending
// response holds the back end until it is accepted. Synchronous active-high reset
// empties the directory and the queue; table RAMs are not cleared.
module tile_directory_decode_lookup_unit #(
   parameter int MAX_ENTRIES = tdl_pkg::MAX_ENTRIES_DEFAULT,
   localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last_byte,
   input  logic [63:0]   req_query_tile_id,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_status,
   output logic [CW-1:0] rsp_entry_count,
   output logic [63:0]   rsp_found_tile_id,
   output logic [63:0]   rsp_found_offset,
   output logic [31:0]   rsp_found_length,
   output logic [31:0]   rsp_found_run
);

   tdl_pkg::queue_head_type head;
   logic pop;

   tdl_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte), .req_query_tile_id(req_query_tile_id),
      .head(head), .pop(pop)
   );

   tdl_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_entry_count(rsp_entry_count),
      .rsp_found_tile_id(rsp_found_tile_id), .rsp_found_offset(rsp_found_offset),
      .rsp_found_length(rsp_found_length), .rsp_found_run(rsp_found_run)
   );

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= 32'(MAX_ENTRIES)))
      else $error("entry count beyond capacity");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == tdl_pkg::ST_MISS) |->
      (rsp_found_tile_id == '0 && rsp_found_run == '0 && rsp_found_offset == '0))
      else $error("miss carries entry fields");

   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == tdl_pkg::ST_TRUNCATED ||
                     rsp_status == tdl_pkg::ST_TOO_LARGE)) |-> (rsp_entry_count == '0))
      else $error("failed load left entries");

   a_leaf_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == tdl_pkg::ST_LEAF) |-> (rsp_found_run == '0))
      else $error("leaf pointer with nonzero run");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for tile_directory_decode_lookup_unit: streams encoded
// directories and lookups, predicts every answer in-bench and compares beats.
// Depends on tdl_pkg and the unit RTL only.
module tb_top;

   localparam int NUM_ENTRIES = 1024;
   localparam int CW = $clog2(NUM_ENTRIES + 1);
   localparam int IDLE_LIMIT = 4000;
   localparam int LARGE_DIR = 48;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum int {PH_COUNT, PH_IDS, PH_RUNS, PH_LENS, PH_OFFS, PH_DONE, PH_BIG}
      load_phase_type;

   typedef struct {
      logic [2:0]    status;
      logic [CW-1:0] count;
      logic [63:0]   tile_id;
      logic [63:0]   offset;
      logic [31:0]   length;
      logic [31:0]   run;
   } dir_answer_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_command = 1'b0;
   logic [7:0]    req_data_byte = '0;
   logic          req_last_byte = 1'b0;
   logic [63:0]   req_query_tile_id = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [2:0]    rsp_status;
   logic [CW-1:0] rsp_entry_count;
   logic [63:0]   rsp_found_tile_id;
   logic [63:0]   rsp_found_offset;
   logic [31:0]   rsp_found_length;
   logic [31:0]   rsp_found_run;

   tile_directory_decode_lookup_unit #(.MAX_ENTRIES(NUM_ENTRIES)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // directory shadow
   logic [63:0] dir_ids [NUM_ENTRIES];
   logic [31:0] dir_runs [NUM_ENTRIES];
   logic [31:0] dir_lens [NUM_ENTRIES];
   logic [63:0] dir_offs [NUM_ENTRIES];
   logic [63:0] vint_acc = '0;
   int unsigned vint_idx = 0;
   load_phase_type phase = PH_COUNT;
   int unsigned declared = 0;
   int unsigned col = 0;
   logic [63:0] tile_sum = '0;
   logic [63:0] prev_end = '0;
   int unsigned held_count = 0;

   dir_answer_type answers_due[$];
   logic [7:0]  stream[$];
   logic [63:0] cur_ids[$];
   int          errors = 0;
   int          beats_sent = 0;
   bit          quiet = 1'b0;
   int          rsp_stall = 0;
   int          idle_cycles = 0;

   function automatic void restart_loader();
      vint_acc = '0;
      vint_idx = 0;
      phase = PH_COUNT;
      declared = 0;
      col = 0;
      tile_sum = '0;
      prev_end = '0;
   endfunction

   function automatic void take_field(logic [63:0] v);
      logic [63:0] off;
      if (phase == PH_COUNT) begin
         if (v > NUM_ENTRIES) begin
            phase = PH_BIG;
         end else if (v == 0) begin
            declared = 0;
            phase = PH_DONE;
         end else begin
            declared = 32'(v);
            col = 0;
            tile_sum = '0;
            phase = PH_IDS;
         end
         return;
      end
      case (phase)
         PH_IDS: begin
            tile_sum = tile_sum + v;
            dir_ids[col] = tile_sum;
         end
         PH_RUNS: dir_runs[col] = v[31:0];
         PH_LENS: dir_lens[col] = v[31:0];
         PH_OFFS: begin
            if (col > 0 && v == 0) off = prev_end;
            else off = (v > 0) ? v - 1 : 64'd0;
            dir_offs[col] = off;
            prev_end = off + {32'd0, dir_lens[col]};
         end
         default: return;
      endcase
      col++;
      if (col >= declared) begin
         col = 0;
         phase = load_phase_type'(phase + 1);
      end
   endfunction

   function automatic bit predict_beat(logic cmd, logic [7:0] b, logic last,
                                       logic [63:0] q, output dir_answer_type a);
      bit pending;
      int unsigned lo, hi, mid, e;
      a = '{status: tdl_pkg::ST_MISS, count: '0, tile_id: '0, offset: '0, length: '0,
            run: '0};
      pending = 1'b0;
      if (cmd == CMD_LOAD) begin
         held_count = 0;
         if (phase < PH_DONE) begin
            if (vint_idx * 7 < 64) vint_acc = vint_acc | ({57'd0, b[6:0]} << (vint_idx * 7));
            if (b[7]) begin
               if (vint_idx < 15) vint_idx++;
               pending = 1'b1;
            end else begin
               logic [63:0] v;
               v = vint_acc;
               vint_acc = '0;
               vint_idx = 0;
               take_field(v);
            end
         end
         if (!last) return 1'b0;
         if (phase == PH_DONE && !pending) begin
            a.status = tdl_pkg::ST_LOADED;
            held_count = declared;
         end else if (phase == PH_BIG) begin
            a.status = tdl_pkg::ST_TOO_LARGE;
         end else begin
            a.status = tdl_pkg::ST_TRUNCATED;
         end
         a.count = CW'(held_count);
         restart_loader();
         return 1'b1;
      end
      a.count = CW'(held_count);
      lo = 0;
      hi = held_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (q < dir_ids[mid]) hi = mid;
         else lo = mid + 1;
      end
      if (lo == 0) return 1'b1;
      e = lo - 1;
      if (dir_runs[e] == 0) a.status = tdl_pkg::ST_LEAF;
      else if (q - dir_ids[e] < {32'd0, dir_runs[e]}) a.status = tdl_pkg::ST_HIT;
      else return 1'b1;
      a.tile_id = dir_ids[e];
      a.offset = dir_offs[e];
      a.length = dir_lens[e];
      a.run = dir_runs[e];
      return 1'b1;
   endfunction

   task automatic send_beat(logic cmd, logic [7:0] b, logic last, logic [63:0] q);
      dir_answer_type a;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_byte <= b;
      req_last_byte <= last;
      req_query_tile_id <= q;
      do @(posedge clock); while (!req_ready);
      if (predict_beat(cmd, b, last, q, a)) answers_due.push_back(a);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic lookup(logic [63:0] q);
      send_beat(CMD_LOOKUP, 8'($urandom), 1'($urandom), q);
   endtask

   function automatic void push_varint(logic [63:0] v);
      while (v >= 128) begin
         stream.push_back({1'b1, v[6:0]});
         v = v >> 7;
      end
      stream.push_back(v[7:0]);
   endfunction

   // send the first 'upto' bytes of the stream, the last one flagged final
   task automatic send_stream(int upto);
      for (int i = 0; i < upto; i++)
         send_beat(CMD_LOAD, stream[i], i == upto - 1, {$urandom, $urandom});
      stream.delete();
   endtask

   task automatic build_random_dir(int n);
      logic [63:0] id;
      id = '0;
      cur_ids.delete();
      stream.delete();
      push_varint(64'(n));
      for (int i = 0; i < n; i++) begin
         logic [63:0] d;
         case ($urandom_range(0, 9))
            0: d = {$urandom, $urandom};
            1: d = 0;
            default: d = 64'($urandom_range(1, 40));
         endcase
         push_varint(d);
         id = id + d;
         cur_ids.push_back(id);
      end
      for (int i = 0; i < n; i++)
         push_varint($urandom_range(0, 3) == 0 ? 64'd0 :
                     ($urandom_range(0, 7) == 0 ? {$urandom, $urandom}
                                                : 64'($urandom_range(1, 20))));
      for (int i = 0; i < n; i++)
         push_varint($urandom_range(0, 5) == 0 ? {32'd0, $urandom}
                                               : 64'($urandom_range(0, 5000)));
      for (int i = 0; i < n; i++)
         push_varint($urandom_range(0, 2) == 0 ? 64'd0
                                               : {$urandom, $urandom} >> $urandom_range(0, 63));
   endtask

   task automatic test_empty_and_zero_count();
      lookup('0);
      lookup('1);
      stream.push_back(8'h00);
      send_stream(1);
      lookup(64'd5);
   endtask

   task automatic test_basic_directory();
      logic [63:0] probes [10];
      // ids 5, 15, 35; leaf in the middle; continued and wrapped offsets
      probes = '{64'd4, 64'd5, 64'd7, 64'd8, 64'd15, 64'd1000, 64'd35, 64'd39,
                 64'd40, 64'hFFFF_FFFF_FFFF_FFFF};
      push_varint(64'd3);
      push_varint(64'd5); push_varint(64'd10); push_varint(64'd20);
      push_varint(64'd3); push_varint(64'd0); push_varint(64'h1_0000_0005);
      push_varint(64'd100); push_varint(64'hFFFF_FFFF); push_varint(64'd7);
      push_varint(64'd1); push_varint(64'd0); push_varint('1);
      send_stream(stream.size());
      foreach (probes[i])
         lookup(probes[i]);
   endtask

   task automatic test_wrapped_ids();
      push_varint(64'd2);
      push_varint('1); push_varint(64'd2);
      push_varint(64'd4); push_varint(64'd4);
      push_varint(64'd1); push_varint(64'd2);
      push_varint(64'd0); push_varint(64'd0);
      send_stream(stream.size());
      lookup('0); lookup(64'd1); lookup(64'd3); lookup('1);
   endtask

   task automatic test_failed_streams();
      push_varint(64'(NUM_ENTRIES + 1));
      stream.push_back(8'hFF); stream.push_back(8'h12);
      send_stream(stream.size());
      lookup(64'd0);
      push_varint(64'd2);
      stream.push_back(8'h85);
      send_stream(stream.size());
      push_varint(64'd2); push_varint(64'd1);
      send_stream(stream.size());
      lookup(64'd1);
   endtask

   task automatic test_long_varint_and_trailing();
      stream.push_back(8'h81);
      repeat (12) stream.push_back(8'hFF);
      stream.push_back(8'h00);
      push_varint(64'd9); push_varint(64'd0); push_varint(64'd3); push_varint(64'd6);
      stream.push_back(8'h99); stream.push_back(8'h00);
      send_stream(stream.size());
      lookup(64'd9); lookup(64'd8);
   endtask

   task automatic test_large_directory();
      // a count at capacity that ends early, then a complete directory of LARGE_DIR entries
      push_varint(64'(NUM_ENTRIES));
      push_varint(64'd1); push_varint(64'd1);
      send_stream(stream.size());
      lookup(64'd1);
      push_varint(64'(LARGE_DIR));
      repeat (LARGE_DIR) push_varint(64'd1);
      repeat (LARGE_DIR) push_varint(64'd1);
      repeat (LARGE_DIR) push_varint(64'd2);
      repeat (LARGE_DIR) push_varint(64'd0);
      send_stream(stream.size());
      lookup(64'd0); lookup(64'd1); lookup(64'd24); lookup(64'(LARGE_DIR));
      lookup(64'(LARGE_DIR + 1));
   endtask

   task automatic test_random_traffic();
      while (beats_sent < 500) begin
         if (beats_sent > 440) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0: begin
               build_random_dir($urandom_range(1, 6));
               send_stream($urandom_range(1, stream.size() - 1));
            end
            1: begin
               repeat ($urandom_range(1, 5))
                  send_beat(CMD_LOAD, 8'($urandom), 1'b0, {$urandom, $urandom});
               if ($urandom_range(0, 1)) lookup({$urandom, $urandom});
               send_beat(CMD_LOAD, 8'($urandom), 1'b1, {$urandom, $urandom});
            end
            2: repeat (3) lookup({$urandom, $urandom});
            default: begin
               build_random_dir($urandom_range(0, 9) == 0 ? $urandom_range(9, 40)
                                                          : $urandom_range(1, 8));
               send_stream(stream.size());
               repeat ($urandom_range(3, 8)) begin
                  if (cur_ids.size() > 0)
                     lookup(cur_ids[$urandom_range(0, cur_ids.size() - 1)]
                            + 64'($urandom_range(0, 24)) - 64'd4);
                  else
                     lookup({$urandom, $urandom});
               end
            end
         endcase
      end
   endtask

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      dir_answer_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected beat, status %0d", $time, rsp_status);
            errors++;
         end else begin
            a = answers_due.pop_front();
            if (rsp_status !== a.status || rsp_entry_count !== a.count ||
                rsp_found_tile_id !== a.tile_id || rsp_found_offset !== a.offset ||
                rsp_found_length !== a.length || rsp_found_run !== a.run) begin
               $display("%0t: expected st=%0d cnt=%0d id=%h off=%h len=%h run=%h", $time,
                        a.status, a.count, a.tile_id, a.offset, a.length, a.run);
               $display("%0t:   actual st=%0d cnt=%0d id=%h off=%h len=%h run=%h", $time,
                        rsp_status, rsp_entry_count, rsp_found_tile_id, rsp_found_offset,
                        rsp_found_length, rsp_found_run);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_and_zero_count();
      test_basic_directory();
      test_wrapped_ids();
      test_failed_streams();
      test_long_varint_and_trailing();
      test_large_directory();
      test_random_traffic();
      req_valid <= 1'b0;
      wait (answers_due.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

FILE: tile_directory_decode_lookup_unit.f
hdl/tdl_pkg.sv
hdl/tdl_ram.sv
hdl/tdl_front.sv
hdl/tdl_back.sv
hdl/tile_directory_decode_lookup_unit.sv
bench/tb_top.sv
